[hdl/tihai_pkg.sv]
// Shared types and constants for the tihai rhythm pattern generator.
// Holds the request/result beat structs, the queue entry and the job kind codes.
// No dependencies.
`timescale 1ns / 1ps

package tihai_pkg;

  localparam int MaxSteps = 64;
  localparam int StepW    = $clog2(MaxSteps + 1);
  localparam int IdxW     = $clog2(MaxSteps);
  localparam int RepW     = 7;
  localparam int AccW     = ((StepW > RepW) ? StepW : RepW) + 1;
  localparam int QDepth   = 2;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  typedef struct packed {
    logic [StepW-1:0] step_count;
    logic [RepW-1:0]  repeat_count;
    logic             pseudo_mode;
  } req_t;

  typedef struct packed {
    logic [MaxSteps-1:0] rhythm_word;
    logic [StepW-1:0]    rhythm_length;
  } res_t;

  typedef enum logic [1:0] {
    KIND_ONES  = 2'd0,
    KIND_ZEROS = 2'd1,
    KIND_CALC  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [StepW-1:0] steps;
    logic [RepW-1:0]  reps;
    logic             pseudo;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
    job_t head;
  } q_stat_t;

endpackage

[hdl/tihai_rhythm_pattern_generator.sv]
// Flow: trivial cases (ones/zeros) go from the queue straight to the bit-serial word build;
// computed cases first run one ceiling division pass per pseudo step, then the build.
// The back end takes no new job until the word of the last one has been sent;
// pseudo shortening adds a division pass after each dropped step that leaves over two steps.
// A two-deep queue takes up to two further beats while the back end works.
// Reset: rst_ni async active low, clears queue and engine; the receiver cannot stall.
`timescale 1ns / 1ps

module tihai_rhythm_pattern_generator import tihai_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic valid_o,
  output res_t res_o
);

  push_t   push;
  q_stat_t q_stat;
  logic    pop;

  // front: saturate and classify each accepted beat
  tihai_front u_front (
    .req_i   (req_i),
    .start_i (start),
    .q_full_i(q_stat.full),
    .busy_o  (busy),
    .push_o  (push)
  );

  // hold classified jobs so front and back stall independently
  tihai_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .pop_i (pop),
    .stat_o(q_stat)
  );

  // back: divide, check for degenerate words, build the word bit by bit
  tihai_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_i    (q_stat),
    .pop_o  (pop),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

`ifndef NO_ASSERTIONS
  // a result beat never lasts longer than one cycle
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe held");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> res_o.rhythm_length <= StepW'(MaxSteps)) else $error("length too large");

  a_upper_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (res_o.rhythm_word >> res_o.rhythm_length) == '0)
    else $error("bits above length set");

  // back end only draws from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty) else $error("pop from empty queue");
`endif

endmodule

[hdl/tihai_front.sv]
// Front end: takes request beats, saturates the step count and sorts out the
// trivial cases before the job is queued. Depends on tihai_pkg.
`timescale 1ns / 1ps

module tihai_front import tihai_pkg::*; (
  input  req_t  req_i,
  input  logic  start_i,
  input  logic  q_full_i,
  output logic  busy_o,
  output push_t push_o
);

  logic [StepW-1:0] steps_sat;
  kind_e            kind;

  always_comb begin
    steps_sat = (req_i.step_count > StepW'(MaxSteps)) ? StepW'(MaxSteps) : req_i.step_count;
    if (steps_sat <= StepW'(2) || req_i.repeat_count == RepW'(1)) begin
      kind = KIND_ONES;
    end else if (req_i.repeat_count == '0) begin
      kind = KIND_ZEROS;
    end else begin
      kind = KIND_CALC;
    end
  end

  assign busy_o            = q_full_i;
  assign push_o.valid      = start_i && !q_full_i;
  assign push_o.job.kind   = kind;
  assign push_o.job.steps  = steps_sat;
  assign push_o.job.reps   = req_i.repeat_count;
  assign push_o.job.pseudo = req_i.pseudo_mode;

endmodule

[hdl/tihai_queue.sv]
// Short job queue between front and back end.
// Depends on tihai_pkg.
`timescale 1ns / 1ps

module tihai_queue import tihai_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  input  logic    pop_i,
  output q_stat_t stat_o
);

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign do_push = push_i.valid && (cnt_q != QCntW'(QDepth));
  assign do_pop  = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.head  = mem_q[rd_ptr_q];

endmodule

[hdl/tihai_back.sv]
// Back end: ceiling division by repeated addition, degenerate check with
// pseudo shortening, then bit-serial build of the rhythm word. Depends on tihai_pkg.
`timescale 1ns / 1ps

module tihai_back import tihai_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_stat_t q_i,
  output logic    pop_o,
  output logic    valid_o,
  output res_t    res_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_EVAL,
    ST_GEN,
    ST_OUT
  } state_e;

  state_e              state_q;
  kind_e               mode_q;
  logic [StepW-1:0]    steps_q, s_q, q_q, hits_q, ph_q;
  logic [RepW-1:0]     m_q;
  logic                pseudo_q;
  logic [AccW-1:0]     acc_q;
  logic [IdxW-1:0]     idx_q;
  logic [MaxSteps-1:0] word_q;
  logic                valid_q;

  logic [AccW-1:0]  rests;
  logic             zero_deg, ones_deg;
  logic [StepW-1:0] idx_ext;
  logic             gen_bit;

  always_comb begin
    rests    = acc_q - AccW'(s_q);
    zero_deg = AccW'(q_q) <= rests;
    ones_deg = (rests == '0);
    idx_ext  = StepW'(idx_q);
    gen_bit  = (idx_ext < steps_q) &&
               ((idx_ext >= s_q) || (mode_q == KIND_ONES) ||
                ((mode_q == KIND_CALC) && (ph_q < hits_q)));
  end

  assign pop_o = (state_q == ST_IDLE) && !q_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mode_q   <= KIND_ONES;
      steps_q  <= '0;
      s_q      <= '0;
      q_q      <= '0;
      hits_q   <= '0;
      ph_q     <= '0;
      m_q      <= '0;
      pseudo_q <= 1'b0;
      acc_q    <= '0;
      idx_q    <= '0;
      word_q   <= '0;
      valid_q  <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (!q_i.empty) begin
            mode_q   <= q_i.head.kind;
            steps_q  <= q_i.head.steps;
            s_q      <= q_i.head.steps;
            m_q      <= q_i.head.reps;
            pseudo_q <= q_i.head.pseudo;
            acc_q    <= '0;
            q_q      <= '0;
            idx_q    <= '0;
            ph_q     <= '0;
            state_q  <= (q_i.head.kind == KIND_CALC) ? ST_DIV : ST_GEN;
          end
        end
        ST_DIV: begin
          // advance until acc reaches the step count: q = ceil(s / m)
          if (acc_q < AccW'(s_q)) begin
            acc_q <= acc_q + AccW'(m_q);
            q_q   <= q_q + 1'b1;
          end else begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (zero_deg || ones_deg) begin
            if (pseudo_q) begin
              // drop one step and retry; at two steps everything is a hit
              s_q   <= s_q - 1'b1;
              acc_q <= '0;
              q_q   <= '0;
              if (s_q - 1'b1 <= StepW'(2)) begin
                mode_q  <= KIND_ONES;
                state_q <= ST_GEN;
              end else begin
                state_q <= ST_DIV;
              end
            end else begin
              mode_q  <= zero_deg ? KIND_ZEROS : KIND_ONES;
              state_q <= ST_GEN;
            end
          end else begin
            // period is hits + rests, which equals the quotient
            hits_q  <= q_q - StepW'(rests);
            mode_q  <= KIND_CALC;
            state_q <= ST_GEN;
          end
        end
        ST_GEN: begin
          word_q <= {gen_bit, word_q[MaxSteps-1:1]};
          ph_q   <= (ph_q == q_q - 1'b1) ? '0 : ph_q + 1'b1;
          idx_q  <= idx_q + 1'b1;
          if (idx_q == IdxW'(MaxSteps - 1)) begin
            valid_q <= 1'b1;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign valid_o             = valid_q;
  assign res_o.rhythm_word   = word_q;
  assign res_o.rhythm_length = steps_q;

endmodule
